[design/pci_pkg.sv]
// pci_pkg: shared types and constants of the palette color indexer
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package pci_pkg;

	localparam int CH_W     = 8;
	localparam int RGB_W    = 3 * CH_W;
	localparam int ID_W     = 8;
	localparam int REQ_W    = 2;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 1;
	// width of one squared 8-bit difference, and of the sum of three
	localparam int SQ_W     = 2 * CH_W;
	localparam int DIST_W   = SQ_W + 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INDEX = 2'd2;

	// register indexes
	localparam logic [CFG_IX_W-1:0] CFG_APPROX    = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_ALLOW_ADD = 2'd1;

	typedef enum logic [1:0] {
		RES_HIT,
		RES_ADD,
		RES_NEAREST,
		RES_NOPAL
	} res_sel_t;

	typedef struct packed {
		logic     clear;
		logic     load;
		logic     start;
		logic     scan;
		logic     add;
		logic     load_out;
		res_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic scan_last;
		logic pipe_empty;
		logic match_found;
	} dp_sts_t;

endpackage

`default_nettype wire

[design/pci_if.sv]
// pci_if: valid/ready channel interfaces of the palette color indexer
// depends on pci_pkg for field widths
`default_nettype none

interface pci_req_if;
	import pci_pkg::*;
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [ID_W-1:0]  entry_id;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;

	modport source (output valid, req_type, entry_id, red, green, blue, input ready);
	modport sink (input valid, req_type, entry_id, red, green, blue, output ready);
endinterface

interface pci_res_if;
	import pci_pkg::*;
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] color_id;
	logic            was_added;
	logic            exact_hit;
	logic            no_palette;

	modport source (output valid, color_id, was_added, exact_hit, no_palette, input ready);
	modport sink (input valid, color_id, was_added, exact_hit, no_palette, output ready);
endinterface

interface pci_cfg_if;
	import pci_pkg::*;
	logic                valid;
	logic                ready;
	logic [CFG_IX_W-1:0] index;
	logic [CFG_D_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/palette_color_indexer.sv]
// palette_color_indexer: nearest-color palette quantizer, top level
// clear and load requests are handled in the idle state; an index result follows a scan over
// every palette slot, the drain of the three-stage distance pipeline and a decision step, or
// the decision step alone on an empty palette; the next request is taken from the cycle the
// result appears, and the decision step waits while a previous result still sits in the
// output register
// async active-low reset empties the palette and clears both mode registers
// depends on pci_pkg, pci_if, pci_ctrl and pci_datapath
`default_nettype none

module palette_color_indexer #(
	parameter int PALETTE_DEPTH = 256
) (
	input wire        clk,
	input wire        arst_n,
	pci_req_if.sink   req,
	pci_res_if.source result,
	pci_cfg_if.sink   cfg
);
	import pci_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	pci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_type  (req.req_type),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pci_datapath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_id   (req.entry_id),
		.red        (req.red),
		.green      (req.green),
		.blue       (req.blue),
		.cmd        (cmd),
		.sts        (sts),
		.color_id   (result.color_id),
		.was_added  (result.was_added),
		.exact_hit  (result.exact_hit),
		.no_palette (result.no_palette)
	);

endmodule

`default_nettype wire

[design/pci_ctrl.sv]
// pci_ctrl: request sequencer, mode registers and result-valid flag
// depends on pci_pkg; drives the command struct of pci_datapath
`default_nettype none

module pci_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  wire  [pci_pkg::REQ_W-1:0]    req_type,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [pci_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire  [pci_pkg::CFG_D_W-1:0]  cfg_data,
	output logic                         res_valid,
	input  wire                          res_ready,
	output pci_pkg::dp_cmd_t             cmd,
	input  wire pci_pkg::dp_sts_t        sts
);
	import pci_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       approx_q;
	logic       allow_add_q;
	logic       res_valid_q;
	logic       req_xfer;
	logic       res_free;
	res_sel_t   sel;

	assign req_ready = (state_q == ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	// output register can take a new result this cycle
	assign res_free  = !res_valid_q || res_ready;

	always_comb begin
		if (sts.count_zero) begin
			sel = allow_add_q ? RES_ADD : RES_NOPAL;
		end else if (!approx_q && sts.match_found) begin
			sel = RES_HIT;
		end else if (!approx_q && allow_add_q && !sts.count_full) begin
			sel = RES_ADD;
		end else begin
			sel = RES_NEAREST;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.clear    = 1'b0;
		cmd.load     = 1'b0;
		cmd.start    = 1'b0;
		cmd.scan     = 1'b0;
		cmd.add      = 1'b0;
		cmd.load_out = 1'b0;
		cmd.sel      = sel;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					case (req_type)
						REQ_CLEAR: cmd.clear = 1'b1;
						REQ_LOAD:  cmd.load  = 1'b1;
						REQ_INDEX: begin
							cmd.start = 1'b1;
							state_d   = sts.count_zero ? ST_FINISH : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (res_free) begin
					cmd.load_out = 1'b1;
					cmd.add      = (sel == RES_ADD);
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			approx_q    <= 1'b0;
			allow_add_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_APPROX:    approx_q    <= cfg_data[0];
					CFG_ALLOW_ADD: allow_add_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[design/pci_datapath.sv]
// pci_datapath: palette memory, valid bits, entry count, distance pipeline and result register
// depends on pci_pkg; sequenced by pci_ctrl through dp_cmd_t / dp_sts_t
`default_nettype none

module pci_datapath #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire  [pci_pkg::ID_W-1:0]  entry_id,
	input  wire  [pci_pkg::CH_W-1:0]  red,
	input  wire  [pci_pkg::CH_W-1:0]  green,
	input  wire  [pci_pkg::CH_W-1:0]  blue,
	input  wire pci_pkg::dp_cmd_t     cmd,
	output pci_pkg::dp_sts_t          sts,
	output logic [pci_pkg::ID_W-1:0]  color_id,
	output logic                      was_added,
	output logic                      exact_hit,
	output logic                      no_palette
);
	import pci_pkg::*;

	localparam int IW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [RGB_W-1:0]         mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] valid_q;
	logic [CW-1:0]            count_q;
	logic [RGB_W-1:0]         pix_q;
	logic [IW-1:0]            scan_q;

	logic                     busy_s1;
	logic                     ent_s1;
	logic [IW-1:0]            idx_s1;
	logic [RGB_W-1:0]         rgb_s1;

	logic                     busy_s2;
	logic                     ent_s2;
	logic [IW-1:0]            idx_s2;
	logic                     eq_s2;
	logic [SQ_W-1:0]          sqr_s2;
	logic [SQ_W-1:0]          sqg_s2;
	logic [SQ_W-1:0]          sqb_s2;

	logic                     busy_s3;
	logic                     ent_s3;
	logic [IW-1:0]            idx_s3;
	logic                     eq_s3;
	logic [DIST_W-1:0]        dist_s3;

	logic [DIST_W-1:0]        best_q;
	logic [IW-1:0]            best_id_q;
	logic                     match_q;
	logic [IW-1:0]            match_id_q;

	logic [RGB_W-1:0]         in_rgb;
	logic                     load_ok;
	logic                     wr_en;
	logic [IW-1:0]            wr_addr;
	logic [RGB_W-1:0]         wr_data;
	logic [CH_W-1:0]          dr;
	logic [CH_W-1:0]          dg;
	logic [CH_W-1:0]          db;

	assign in_rgb  = {red, green, blue};
	assign load_ok = cmd.load && (int'(entry_id) < PALETTE_DEPTH);
	assign wr_en   = load_ok || cmd.add;
	// an added pixel goes to the slot named by the entry count
	assign wr_addr = cmd.add ? count_q[IW-1:0] : entry_id[IW-1:0];
	assign wr_data = cmd.add ? pix_q : in_rgb;

	assign dr = abs_diff(rgb_s1[RGB_W-1 -: CH_W], pix_q[RGB_W-1 -: CH_W]);
	assign dg = abs_diff(rgb_s1[CH_W +: CH_W], pix_q[CH_W +: CH_W]);
	assign db = abs_diff(rgb_s1[CH_W-1:0], pix_q[CH_W-1:0]);

	assign sts.count_zero  = (count_q == '0);
	assign sts.count_full  = (count_q == CW'(PALETTE_DEPTH));
	assign sts.scan_last   = (scan_q == IW'(PALETTE_DEPTH - 1));
	assign sts.pipe_empty  = !busy_s1 && !busy_s2 && !busy_s3;
	assign sts.match_found = match_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rgb_s1 <= mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (wr_en && !valid_q[wr_addr]) begin
			valid_q[wr_addr] <= 1'b1;
			count_q          <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			busy_s1 <= 1'b0;
			busy_s2 <= 1'b0;
			busy_s3 <= 1'b0;
		end else begin
			if (cmd.start) begin
				scan_q <= '0;
			end else if (cmd.scan) begin
				scan_q <= sts.scan_last ? '0 : scan_q + IW'(1);
			end
			busy_s1 <= cmd.scan;
			busy_s2 <= busy_s1;
			busy_s3 <= busy_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pix_q <= in_rgb;
		end
		ent_s1  <= valid_q[scan_q];
		idx_s1  <= scan_q;

		ent_s2  <= ent_s1;
		idx_s2  <= idx_s1;
		eq_s2   <= (rgb_s1 == pix_q);
		sqr_s2  <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2  <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2  <= SQ_W'(db) * SQ_W'(db);

		ent_s3  <= ent_s2;
		idx_s3  <= idx_s2;
		eq_s3   <= eq_s2;
		dist_s3 <= DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);
	end

	// nearest keeps the lowest id on ties, exact match keeps the highest id
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_q     <= '1;
			best_id_q  <= '0;
			match_q    <= 1'b0;
			match_id_q <= '0;
		end else if (busy_s3 && ent_s3) begin
			if (dist_s3 < best_q) begin
				best_q    <= dist_s3;
				best_id_q <= idx_s3;
			end
			if (eq_s3) begin
				match_q    <= 1'b1;
				match_id_q <= idx_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.sel)
				RES_HIT: begin
					color_id   <= ID_W'(match_id_q);
					was_added  <= 1'b0;
					exact_hit  <= 1'b1;
					no_palette <= 1'b0;
				end
				RES_ADD: begin
					color_id   <= ID_W'(count_q[IW-1:0]);
					was_added  <= 1'b1;
					exact_hit  <= 1'b0;
					no_palette <= 1'b0;
				end
				RES_NEAREST: begin
					color_id   <= ID_W'(best_id_q);
					was_added  <= 1'b0;
					exact_hit  <= (best_q == '0);
					no_palette <= 1'b0;
				end
				default: begin
					color_id   <= '0;
					was_added  <= 1'b0;
					exact_hit  <= 1'b0;
					no_palette <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[test/pci_checker.sv]
// pci_checker: watches the request, result and register channels of the palette color indexer,
// keeps its own copy of the palette and predicts every index result in order
// depends on pci_pkg and pci_if
`default_nettype none

module pci_checker
	import pci_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  wire  clk,
	input  wire  arst_n,
	pci_req_if   req,
	pci_res_if   result,
	pci_cfg_if   cfg,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [ID_W-1:0] color_id;
		logic            was_added;
		logic            exact_hit;
		logic            no_palette;
	} pix_result_t;

	logic [RGB_W-1:0] pal_rgb [DEPTH];
	bit               pal_used [DEPTH];
	int unsigned      n_used;
	bit               mode_approx;
	bit               mode_add;
	pix_result_t      expected_q [$];

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic int unsigned rgb_dist(input logic [RGB_W-1:0] a, input logic [RGB_W-1:0] b);
		int dr, dg, db;
		dr = int'(a[23:16]) - int'(b[23:16]);
		dg = int'(a[15:8]) - int'(b[15:8]);
		db = int'(a[7:0]) - int'(b[7:0]);
		return dr * dr + dg * dg + db * db;
	endfunction

	function automatic void store_color(input int unsigned slot, input logic [RGB_W-1:0] px);
		if (!pal_used[slot]) begin
			pal_used[slot] = 1'b1;
			n_used++;
		end
		pal_rgb[slot] = px;
	endfunction

	// updates the palette copy; returns 1 when the request yields a result
	function automatic bit apply_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] slot,
			input logic [RGB_W-1:0] px, output pix_result_t r);
		bit          settled;
		int unsigned best, d;
		r = '0;
		case (kind)
			REQ_CLEAR: begin
				for (int i = 0; i < DEPTH; i++)
					pal_used[i] = 1'b0;
				n_used = 0;
				return 1'b0;
			end
			REQ_LOAD: begin
				if (int'(slot) < DEPTH)
					store_color(32'(slot), px);
				return 1'b0;
			end
			REQ_INDEX: ;
			default: return 1'b0;
		endcase
		if (n_used == 0) begin
			if (mode_add) begin
				store_color(0, px);
				r.was_added = 1'b1;
			end else begin
				r.no_palette = 1'b1;
			end
			return 1'b1;
		end
		settled = 1'b0;
		if (!mode_approx) begin
			// last matching slot wins
			for (int i = 0; i < DEPTH; i++)
				if (pal_used[i] && pal_rgb[i] == px) begin
					r.color_id  = ID_W'(i);
					r.exact_hit = 1'b1;
					settled     = 1'b1;
				end
			if (!settled && mode_add && n_used < DEPTH) begin
				r.color_id  = ID_W'(n_used);
				store_color(n_used, px);
				r.was_added = 1'b1;
				settled     = 1'b1;
			end
		end
		if (!settled) begin
			best = '1;
			for (int i = 0; i < DEPTH; i++)
				if (pal_used[i]) begin
					d = rgb_dist(px, pal_rgb[i]);
					if (d < best) begin
						best       = d;
						r.color_id = ID_W'(i);
					end
				end
			r.exact_hit = (best == 0);
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pix_result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				pal_used[i] = 1'b0;
			n_used      = 0;
			mode_approx = 1'b0;
			mode_add    = 1'b0;
			expected_q.delete();
			errors      = 0;
			pending    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_APPROX:    mode_approx = cfg.data[0];
					CFG_ALLOW_ADD: mode_add    = cfg.data[0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = '{result.color_id, result.was_added, result.exact_hit, result.no_palette};
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, color_id %0d",
						got.color_id));
				end else begin
					want = expected_q.pop_front();
					if (got.color_id !== want.color_id)
						report_mismatch($sformatf("color_id got %0d expected %0d",
							got.color_id, want.color_id));
					if (got.was_added !== want.was_added)
						report_mismatch($sformatf("was_added got %0b expected %0b",
							got.was_added, want.was_added));
					if (got.exact_hit !== want.exact_hit)
						report_mismatch($sformatf("exact_hit got %0b expected %0b",
							got.exact_hit, want.exact_hit));
					if (got.no_palette !== want.no_palette)
						report_mismatch($sformatf("no_palette got %0b expected %0b",
							got.no_palette, want.no_palette));
				end
			end
			if (req.valid && req.ready)
				if (apply_request(req.req_type, req.entry_id, {req.red, req.green, req.blue}, want))
					expected_q.push_back(want);
			pending <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

[test/palette_color_indexer_tb.sv]
// palette_color_indexer_tb: drives requests and mode writes into the palette color indexer,
// stalls the result side at random and gives the verdict from the checker's error count
// depends on pci_pkg, pci_if, palette_color_indexer and pci_checker
`default_nettype none

module palette_color_indexer_tb;
	import pci_pkg::*;

	localparam int DEPTH       = 256;
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 650;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pci_req_if req_ch ();
	pci_res_if res_ch ();
	pci_cfg_if cfg_ch ();

	int               errors;
	int               pending;
	int               sent;
	int               quiet;
	bit               send_calm;
	bit               drain_calm;
	int unsigned      drain_hold;
	bit               fill_done;
	logic [RGB_W-1:0] hue_pool [6];

	palette_color_indexer #(
		.PALETTE_DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	pci_checker #(
		.DEPTH(DEPTH)
	) chk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.result (res_ch),
		.cfg    (cfg_ch),
		.errors (errors),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [RGB_W-1:0] pick_color();
		logic [RGB_W-1:0] c;
		case ($urandom_range(0, 5))
			0, 1, 2: c = hue_pool[$urandom_range(0, 5)];
			3: c = {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
				($urandom_range(0, 1) ? 8'hFF : 8'h00)};
			default: c = RGB_W'($urandom);
		endcase
		return c;
	endfunction

	function automatic logic [ID_W-1:0] pick_slot();
		return ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
	endfunction

	// valid stays high across back-to-back transfers
	task automatic send(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] slot,
			input logic [RGB_W-1:0] px);
		int unsigned gap;
		gap = send_calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.entry_id <= slot;
		req_ch.red      <= px[23:16];
		req_ch.green    <= px[15:8];
		req_ch.blue     <= px[7:0];
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (kind != REQ_UNUSED)
			sent++;
	endtask

	task automatic write_modes(input bit approx, input bit add);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_APPROX;
		cfg_ch.data  <= approx;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.index <= CFG_ALLOW_ADD;
		cfg_ch.data  <= add;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// wait for every pending result, then let clears and loads behind it finish
	task automatic settle(input int tail);
		req_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : drain
		int unsigned w;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			drain_hold   <= 0;
			drain_calm   <= 1'b0;
		end else if (res_ch.valid && res_ch.ready) begin
			if ($urandom_range(0, 23) == 0)
				drain_calm <= !drain_calm;
			w = drain_calm ? 0 : $urandom_range(0, 19);
			drain_hold   <= w;
			res_ch.ready <= (w == 0);
		end else if (res_ch.valid && !res_ch.ready) begin
			if (drain_hold == 0)
				res_ch.ready <= 1'b1;
			else
				drain_hold <= drain_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		int unsigned nload, npix, combo, phase;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_CLEAR;
		req_ch.entry_id <= '0;
		req_ch.red      <= '0;
		req_ch.green    <= '0;
		req_ch.blue     <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= CFG_APPROX;
		cfg_ch.data     <= '0;
		sent             = 0;
		send_calm        = 1'b0;
		fill_done        = 1'b0;
		phase            = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty palette, adding off
		write_modes(1'b0, 1'b0);
		send(REQ_INDEX, 8'h00, 24'h000000);
		send(REQ_UNUSED, 8'hA5, 24'h5A5A5A);
		settle(8);
		write_modes(1'b0, 1'b1);
		send(REQ_INDEX, 8'h00, 24'hFFFFFF);
		send(REQ_INDEX, 8'hFF, 24'hFFFFFF);
		send(REQ_INDEX, 8'h00, 24'h000000);
		// duplicate color: highest slot wins
		send(REQ_LOAD, 8'd2, 24'h000000);
		send(REQ_INDEX, 8'h00, 24'h000000);
		send(REQ_LOAD, 8'd1, 24'h0A0000);
		send(REQ_LOAD, 8'd255, 24'hFF00FF);
		send(REQ_INDEX, 8'h00, 24'h00FF00);
		// add lands on an already valid slot of a sparse palette
		send(REQ_CLEAR, 8'h00, 24'h000000);
		send(REQ_LOAD, 8'd1, 24'h323232);
		send(REQ_INDEX, 8'h00, 24'h070707);
		send(REQ_INDEX, 8'h00, 24'h070707);
		settle(8);
		write_modes(1'b1, 1'b0);
		send(REQ_CLEAR, 8'h00, 24'h000000);
		send(REQ_INDEX, 8'h00, 24'h808080);
		send(REQ_LOAD, 8'd0, 24'h640000);
		send(REQ_LOAD, 8'd1, 24'h006400);
		// equal distance to both entries
		send(REQ_INDEX, 8'h00, 24'h323200);
		send(REQ_INDEX, 8'h00, 24'h006400);
		settle(8);
		write_modes(1'b1, 1'b1);
		send(REQ_INDEX, 8'h00, 24'h00FFFF);
		send(REQ_CLEAR, 8'h00, 24'h000000);
		send(REQ_INDEX, 8'h00, 24'h123456);

		while (sent < ITEM_TARGET) begin
			settle(8);
			send_calm = ($urandom_range(0, 4) == 0);
			foreach (hue_pool[k])
				hue_pool[k] = RGB_W'($urandom);
			if (!fill_done && (sent > 250 || $urandom_range(0, 9) == 0)) begin
				// full palette: exact mode with adding on must fall back to nearest
				fill_done = 1'b1;
				write_modes(1'b0, 1'b1);
				send(REQ_CLEAR, ID_W'($urandom), RGB_W'($urandom));
				for (int k = 0; k < DEPTH; k++)
					send(REQ_LOAD, ID_W'(k), pick_color());
				repeat (10) send(REQ_INDEX, ID_W'($urandom), pick_color());
			end else begin
				combo = (phase < 4) ? phase : $urandom_range(0, 3);
				write_modes(combo[1], combo[0]);
				if ($urandom_range(0, 2) == 0)
					send(REQ_CLEAR, ID_W'($urandom), RGB_W'($urandom));
				nload = $urandom_range(0, 6);
				repeat (nload) send(REQ_LOAD, pick_slot(), pick_color());
				npix = $urandom_range(6, 16);
				repeat (npix) begin
					case ($urandom_range(0, 19))
						0: send(REQ_LOAD, pick_slot(), pick_color());
						1: send(REQ_CLEAR, ID_W'($urandom), RGB_W'($urandom));
						2: send(REQ_UNUSED, ID_W'($urandom), RGB_W'($urandom));
						default: send(REQ_INDEX, ID_W'($urandom), pick_color());
					endcase
				end
				phase++;
			end
		end

		// room for one more full scan in case a stray result follows
		settle(300);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

[palette_color_indexer.f]
design/pci_pkg.sv
design/pci_if.sv
design/pci_ctrl.sv
design/pci_datapath.sv
design/palette_color_indexer.sv
test/pci_checker.sv
test/palette_color_indexer_tb.sv
